FILE: hw/rtl/n2seg_pkg.sv
// ----------------------------------------------------------------------------
// n2seg_pkg
// Constants, types and helpers for the number to seven-segment converter.
// ----------------------------------------------------------------------------
package n2seg_pkg;

   localparam int DIGIT_COUNT     = 8;
   localparam int VALUE_W         = 32;
   localparam int BCD_DIGITS      = 10;
   localparam int BCD_W           = 4 * BCD_DIGITS;
   localparam int STEPS_PER_STAGE = 8;
   localparam int STAGE_COUNT     = VALUE_W / STEPS_PER_STAGE;

   typedef logic [7:0]       seg_type;
   typedef logic [3:0]       bcd_digit_type;
   typedef logic [BCD_W-1:0] bcd_type;

   localparam seg_type SEG_BLANK = 8'hff;

   // active-low common-anode patterns
   function automatic seg_type seg_encode(input bcd_digit_type digit);
      seg_type seg;
      unique case (digit)
         4'd0:    seg = 8'hc0;
         4'd1:    seg = 8'hf9;
         4'd2:    seg = 8'ha4;
         4'd3:    seg = 8'hb0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hf8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   // add 3 to every BCD digit of 5 or more, ahead of the next shift
   function automatic bcd_type dabble_adjust(input bcd_type bcd);
      bcd_type adj;
      adj = bcd;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return adj;
   endfunction

endpackage

FILE: hw/rtl/number_to_seven_segment_blanked.sv
// ----------------------------------------------------------------------------
// number_to_seven_segment_blanked
// Converts a 32-bit unsigned word into eight active-low seven-segment
// patterns, leftmost digit first, with leading zeros blanked.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_valid/req_ready carries req_value. Result channel
//   rsp_valid/rsp_ready carries rsp_seg_digit0 (leftmost) through
//   rsp_seg_digit7 (rightmost). Only the eight low decimal digits show;
//   leading zero digits read 0xff, and the rightmost digit is always shown.
//   Path: an accepted word passes one input register, four binary-to-BCD
//   stages of eight shift/add-3 steps each, then the segment encoder into
//   the output register.
//   Throughput: one word per cycle; the pipeline and the output register
//   move together whenever the output register is empty or being taken.
//   Receiver stall: the whole pipeline holds, req_ready drops, and the
//   result word stays on the rsp_ ports until taken.
//   Reset: all stage valid bits and rsp_valid clear; nothing is pending.
// ----------------------------------------------------------------------------
module number_to_seven_segment_blanked (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output n2seg_pkg::seg_type    rsp_seg_digit0,
   output n2seg_pkg::seg_type    rsp_seg_digit1,
   output n2seg_pkg::seg_type    rsp_seg_digit2,
   output n2seg_pkg::seg_type    rsp_seg_digit3,
   output n2seg_pkg::seg_type    rsp_seg_digit4,
   output n2seg_pkg::seg_type    rsp_seg_digit5,
   output n2seg_pkg::seg_type    rsp_seg_digit6,
   output n2seg_pkg::seg_type    rsp_seg_digit7
);
   import n2seg_pkg::*;

   logic                 advance;
   logic                 valid_ff [0:STAGE_COUNT];
   bcd_type              bcd_ff   [0:STAGE_COUNT];
   logic [VALUE_W-1:0]   bin_ff   [0:STAGE_COUNT];
   bcd_type              bcd_in   [1:STAGE_COUNT];
   logic [VALUE_W-1:0]   bin_in   [1:STAGE_COUNT];
   seg_type              seg_in   [0:DIGIT_COUNT-1];
   seg_type              seg_ff   [0:DIGIT_COUNT-1];
   logic                 rsp_valid_ff;

   // move the whole pipeline when the output register is free or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // binary-to-BCD stages
   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
      always_comb begin : dabble_blk
         bcd_type            bcd_w;
         logic [VALUE_W-1:0] bin_w;
         bcd_w = bcd_ff[s];
         bin_w = bin_ff[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            bcd_w = dabble_adjust(bcd_w);
            {bcd_w, bin_w} = {bcd_w[BCD_W-2:0], bin_w, 1'b0};
         end
         bcd_in[s+1] = bcd_w;
         bin_in[s+1] = bin_w;
      end
   end

   // segment encode with leading-zero blanking; rightmost digit always shown
   always_comb begin : encode_blk
      logic          leading;
      bcd_digit_type digit;
      leading = 1'b1;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         digit = bcd_ff[STAGE_COUNT][4*(DIGIT_COUNT-1-k) +: 4];
         if (leading && (digit == 4'd0) && (k != DIGIT_COUNT-1)) begin
            seg_in[k] = SEG_BLANK;
         end else begin
            leading   = 1'b0;
            seg_in[k] = seg_encode(digit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STAGE_COUNT; s++) begin
            valid_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int s = 1; s <= STAGE_COUNT; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         rsp_valid_ff <= valid_ff[STAGE_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bcd_ff[0] <= '0;
         bin_ff[0] <= req_value;
         for (int s = 1; s <= STAGE_COUNT; s++) begin
            bcd_ff[s] <= bcd_in[s];
            bin_ff[s] <= bin_in[s];
         end
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            seg_ff[k] <= seg_in[k];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_seg_digit0 = seg_ff[0];
   assign rsp_seg_digit1 = seg_ff[1];
   assign rsp_seg_digit2 = seg_ff[2];
   assign rsp_seg_digit3 = seg_ff[3];
   assign rsp_seg_digit4 = seg_ff[4];
   assign rsp_seg_digit5 = seg_ff[5];
   assign rsp_seg_digit6 = seg_ff[6];
   assign rsp_seg_digit7 = seg_ff[7];

`ifndef SYNTHESIS
   // rightmost digit is never blank
   a_right_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seg_digit7 != SEG_BLANK))
      else $error("rightmost digit blanked");

   // blanking only covers a leading run: once digit 0 shows, digit 6 shows too
   a_blank_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_seg_digit0 != SEG_BLANK)) |-> (rsp_seg_digit6 != SEG_BLANK))
      else $error("inner digit blanked after a shown digit");

   // an accepted word enters the pipeline
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted word lost at pipeline entry");

   // nothing pending right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
